// ===== hdl/sha256_pkg.sv =====
package sha256_pkg;

    // Field widths of the two streams.
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 32;
    localparam int INDEX_W = 3;
    localparam int COUNT_W = 61;

    // Block geometry: 64 bytes, 16 schedule words, 64 rounds, 8 hash words.
    localparam int BLOCK_BITS = 512;
    localparam int FILL_W     = 6;
    localparam int ROUND_W    = 6;
    localparam int HASH_WORDS = 8;

    // Position in the block where the 64-bit length field starts.
    localparam logic [FILL_W-1:0] LEN_START = 6'd56;
    localparam logic [FILL_W-1:0] LAST_FILL = 6'd63;
    localparam logic [ROUND_W-1:0] LAST_ROUND = 6'd63;
    localparam logic [INDEX_W-1:0] LAST_INDEX = 3'd7;

    // Padding marker byte.
    localparam logic [BYTE_W-1:0] PAD_MARK = 8'h80;

    // Initial hash value, element 0 is the first word.
    localparam logic [HASH_WORDS-1:0][WORD_W-1:0] H_INIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    // Round constants.
    localparam logic [WORD_W-1:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Rotate right by a constant amount.
    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v, input int s);
        return (v >> s) | (v << (WORD_W - s));
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] v);
        return rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] v);
        return rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] v);
        return rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] v);
        return rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
    endfunction

endpackage

// ===== hdl/sha256_stream_hasher.sv =====
// SHA-256 hasher for a byte stream. Each input beat carries one message byte
// (tuser high) and/or the end of the message (tlast). While the block is idle
// it takes one byte per cycle; the 64th byte of a block starts the round unit,
// which runs one round per cycle and then folds the result into the hash;
// s_tready is low meanwhile, so no new byte is taken until the block is done.
// On end of message the padding is shifted in one byte per cycle, over two
// blocks when the length field spills into an extra block; each padded block
// is compressed as above, and the digest leaves as eight 32-bit beats,
// most significant word first, with the last beat flagged by m_tlast. The
// hash state and byte count then return to their initial values, so the
// next message can follow at once.
module sha256_stream_hasher (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sha256_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] data_byte
    input  logic                             s_tuser,   // [0] has_byte
    input  logic                             s_tlast,   // end_of_message
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sha256_pkg::WORD_W-1:0]    m_tdata,   // [31:0] digest_word
    output logic [sha256_pkg::INDEX_W-1:0]   m_tuser,   // [2:0] word_index
    output logic                             m_tlast    // last_word
);
    import sha256_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FIN,
        ST_OUT
    } state_t;

    state_t                            state_reg, state_next;
    logic [BLOCK_BITS-1:0]             msg_reg, msg_next;
    logic [HASH_WORDS-1:0][WORD_W-1:0] hash_reg, hash_next;
    logic [HASH_WORDS-1:0][WORD_W-1:0] work_reg, work_next;
    logic [COUNT_W-1:0]                count_reg, count_next;
    logic [FILL_W-1:0]                 fill_reg, fill_next;
    logic [ROUND_W-1:0]                round_reg, round_next;
    logic [INDEX_W-1:0]                out_idx_reg, out_idx_next;
    logic                              end_reg, end_next;
    logic                              pad_first_reg, pad_first_next;
    logic                              pad_wrap_reg, pad_wrap_next;
    logic                              pad_done_reg, pad_done_next;
    logic                              m_valid_reg, m_valid_next;
    logic [WORD_W-1:0]                 m_data_reg, m_data_next;
    logic [INDEX_W-1:0]                m_index_reg, m_index_next;
    logic                              m_last_reg, m_last_next;

    logic                              in_fire;
    logic                              out_free;
    logic [7:0][BYTE_W-1:0]            len_bytes;
    logic [BYTE_W-1:0]                 pad_byte;
    logic                              pad_is_len;
    logic [WORD_W-1:0]                 w0, w1, w9, w14, w_new;
    logic [WORD_W-1:0]                 t1, t2;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_index_reg;
    assign m_tlast  = m_last_reg;

    // The message length in bits, split into bytes; element 7 is sent first.
    assign len_bytes = {count_reg, 3'b000};

    // Padding byte: the marker first, then zeros, then the length field in
    // the last eight bytes of a block that did not take the marker there.
    always_comb begin
        pad_is_len = !pad_first_reg && !pad_wrap_reg && (fill_reg >= LEN_START);
        if (pad_first_reg) begin
            pad_byte = PAD_MARK;
        end else if (pad_is_len) begin
            pad_byte = len_bytes[3'd7 - fill_reg[2:0]];
        end else begin
            pad_byte = '0;
        end
    end

    // Schedule window taps: w0 is the word used in the current round.
    assign w0    = msg_reg[BLOCK_BITS-1 -: WORD_W];
    assign w1    = msg_reg[BLOCK_BITS-1-WORD_W -: WORD_W];
    assign w9    = msg_reg[BLOCK_BITS-1-9*WORD_W -: WORD_W];
    assign w14   = msg_reg[BLOCK_BITS-1-14*WORD_W -: WORD_W];
    assign w_new = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;

    // Shared round unit.
    always_comb begin
        t1 = work_reg[7] + big_sigma1(work_reg[4])
           + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
           + K_TABLE[round_reg] + w0;
        t2 = big_sigma0(work_reg[0])
           + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
              ^ (work_reg[1] & work_reg[2]));
    end

    // Sequencer.
    always_comb begin
        state_next     = state_reg;
        msg_next       = msg_reg;
        hash_next      = hash_reg;
        work_next      = work_reg;
        count_next     = count_reg;
        fill_next      = fill_reg;
        round_next     = round_reg;
        out_idx_next   = out_idx_reg;
        end_next       = end_reg;
        pad_first_next = pad_first_reg;
        pad_wrap_next  = pad_wrap_reg;
        pad_done_next  = pad_done_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_index_next   = m_index_reg;
        m_last_next    = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    end_next       = s_tlast;
                    pad_first_next = 1'b1;
                    pad_wrap_next  = 1'b0;
                    pad_done_next  = 1'b0;
                    if (s_tuser) begin
                        msg_next   = {msg_reg[BLOCK_BITS-BYTE_W-1:0], s_tdata};
                        count_next = count_reg + 1'b1;
                        fill_next  = fill_reg + 1'b1;
                    end
                    if (s_tuser && fill_reg == LAST_FILL) begin
                        work_next  = hash_reg;
                        round_next = '0;
                        state_next = ST_ROUND;
                    end else if (s_tlast) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                msg_next       = {msg_reg[BLOCK_BITS-BYTE_W-1:0], pad_byte};
                fill_next      = fill_reg + 1'b1;
                pad_first_next = 1'b0;
                if (pad_first_reg && fill_reg >= LEN_START) begin
                    pad_wrap_next = 1'b1;
                end
                if (fill_reg == LAST_FILL) begin
                    pad_wrap_next = 1'b0;
                    pad_done_next = pad_is_len;
                    work_next     = hash_reg;
                    round_next    = '0;
                    state_next    = ST_ROUND;
                end
            end
            ST_ROUND: begin
                msg_next    = {msg_reg[BLOCK_BITS-WORD_W-1:0], w_new};
                work_next   = {work_reg[6:4], work_reg[3] + t1,
                               work_reg[2:0], t1 + t2};
                round_next  = round_reg + 1'b1;
                if (round_reg == LAST_ROUND) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                for (int i = 0; i < HASH_WORDS; i++) begin
                    hash_next[i] = hash_reg[i] + work_reg[i];
                end
                if (pad_done_reg) begin
                    out_idx_next = '0;
                    state_next   = ST_OUT;
                end else if (end_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = hash_reg[out_idx_reg];
                    m_index_next = out_idx_reg;
                    m_last_next  = (out_idx_reg == LAST_INDEX);
                    out_idx_next = out_idx_reg + 1'b1;
                    if (out_idx_reg == LAST_INDEX) begin
                        hash_next  = H_INIT;
                        count_next = '0;
                        end_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            hash_reg      <= H_INIT;
            count_reg     <= '0;
            fill_reg      <= '0;
            round_reg     <= '0;
            out_idx_reg   <= '0;
            end_reg       <= 1'b0;
            pad_first_reg <= 1'b0;
            pad_wrap_reg  <= 1'b0;
            pad_done_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            count_reg     <= count_next;
            fill_reg      <= fill_next;
            round_reg     <= round_next;
            out_idx_reg   <= out_idx_next;
            end_reg       <= end_next;
            pad_first_reg <= pad_first_next;
            pad_wrap_reg  <= pad_wrap_next;
            pad_done_reg  <= pad_done_next;
            m_valid_reg   <= m_valid_next;
        end
        msg_reg     <= msg_next;
        work_reg    <= work_next;
        m_data_reg  <= m_data_next;
        m_index_reg <= m_index_next;
        m_last_reg  <= m_last_next;
    end

    // A block always enters the round unit completely filled.
    a_round_full_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND) |-> (fill_reg == '0))
        else $error("round unit running on a partially filled block");

    // The last round is always followed by the hash update.
    a_round_to_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && round_reg == LAST_ROUND) |=> (state_reg == ST_FIN))
        else $error("hash update skipped after the last round");

    // The last-word flag travels only with the final word index.
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_last_reg == (m_index_reg == LAST_INDEX)))
        else $error("last-word flag does not match the word index");

    // Digest output always starts at the most significant word.
    a_out_start: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == ST_OUT) |-> (out_idx_reg == '0))
        else $error("digest output did not start at word zero");

endmodule
